// File: src/stmf_pkg.sv
// Shared types and constants of the sliding trimmed-mean filter.
// Holds the transaction structs of both channels and the job passed front to back.
// No dependencies.
package stmf_pkg;

  localparam int unsigned SampleBits     = 16;
  localparam int unsigned WindowDef      = 7;
  localparam int unsigned WindowMax      = 15;
  localparam int unsigned QueueDepthDef  = 4;
  localparam int unsigned JobValBits     = SampleBits + $clog2(WindowMax);
  localparam int unsigned JobRepsBits    = $clog2(WindowMax + 1);

  typedef logic [SampleBits-1:0] sample_t;

  typedef struct packed {
    sample_t sample;
    logic    track_last;
  } in_item_t;

  typedef struct packed {
    sample_t filtered;
    logic    run_last;
    logic    track_end;
    logic    unfiltered;
  } out_item_t;

  typedef struct packed {
    logic [JobValBits-1:0]  value;
    logic [JobRepsBits-1:0] reps;
    logic                   run_last;
    logic                   track_end;
    logic                   unfiltered;
  } job_t;

endpackage

// File: src/stmf_front.sv
// Front end of the sliding trimmed-mean filter: window store, fill count, trimmed sum.
// Turns accepted samples into jobs for the queue. Depends on stmf_pkg.
module stmf_front
  import stmf_pkg::*;
#(
  parameter int unsigned WINDOW = WindowDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  input  in_item_t in_item_i,
  output logic     full,
  input  logic     q_full_i,
  output logic     job_push_o,
  output job_t     job_o
);

  localparam int unsigned Depth = WINDOW - 1;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(WINDOW + 1);
  localparam int unsigned SumW  = SampleBits + $clog2(WINDOW);
  localparam int unsigned Lead  = (WINDOW - 1) / 2;
  localparam int unsigned Trail = (WINDOW - 1) - Lead;

  sample_t         store_q [Depth];
  sample_t         store_d [Depth];
  logic [CntW-1:0] seen_q, seen_d;
  logic [CntW-1:0] left_q, left_d;
  logic            drain_q, drain_d;

  logic            accept;
  logic            running;
  logic            drain_push;
  logic [SumW-1:0] sum;
  logic [SumW-1:0] tsum;
  sample_t         lo;
  sample_t         hi;
  logic [JobRepsBits-1:0] reps;

  assign full       = drain_q | q_full_i;
  assign accept     = push & ~full;
  assign running    = seen_q >= CntW'(WINDOW - 1);
  assign drain_push = drain_q & ~q_full_i;

  always_comb begin
    sum = SumW'(in_item_i.sample);
    lo  = in_item_i.sample;
    hi  = in_item_i.sample;
    for (int i = 0; i < Depth; i++) begin
      sum = sum + SumW'(store_q[i]);
      if (store_q[i] < lo) lo = store_q[i];
      if (store_q[i] > hi) hi = store_q[i];
    end
    tsum = sum - SumW'(lo) - SumW'(hi);
  end

  always_comb begin
    reps = JobRepsBits'(1);
    if (seen_q == CntW'(WINDOW - 1)) reps = reps + JobRepsBits'(Lead);
    if (in_item_i.track_last) reps = reps + JobRepsBits'(Trail);
  end

  always_comb begin
    job_push_o = 1'b0;
    job_o      = '0;
    if (drain_push) begin
      job_push_o       = 1'b1;
      job_o.value      = JobValBits'(store_q[0]);
      job_o.reps       = JobRepsBits'(1);
      job_o.run_last   = (left_q == CntW'(1));
      job_o.track_end  = (left_q == CntW'(1));
      job_o.unfiltered = 1'b1;
    end else if (accept && running) begin
      job_push_o       = 1'b1;
      job_o.value      = JobValBits'(tsum);
      job_o.reps       = reps;
      job_o.run_last   = 1'b1;
      job_o.track_end  = in_item_i.track_last;
      job_o.unfiltered = 1'b0;
    end
  end

  always_comb begin
    store_d = store_q;
    seen_d  = seen_q;
    left_d  = left_q;
    drain_d = drain_q;
    if (drain_push) begin
      for (int i = 0; i < Depth - 1; i++) store_d[i] = store_q[i+1];
      left_d = left_q - CntW'(1);
      if (left_q == CntW'(1)) drain_d = 1'b0;
    end else if (accept) begin
      if (running) begin
        for (int i = 0; i < Depth - 1; i++) store_d[i] = store_q[i+1];
        store_d[Depth-1] = in_item_i.sample;
        seen_d = in_item_i.track_last ? '0 : CntW'(WINDOW);
      end else begin
        store_d[seen_q[IdxW-1:0]] = in_item_i.sample;
        if (in_item_i.track_last) begin
          drain_d = 1'b1;
          left_d  = seen_q + CntW'(1);
          seen_d  = '0;
        end else begin
          seen_d = seen_q + CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    store_q <= store_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= '0;
      left_q  <= '0;
      drain_q <= 1'b0;
    end else begin
      seen_q  <= seen_d;
      left_q  <= left_d;
      drain_q <= drain_d;
    end
  end

endmodule

// File: src/stmf_queue.sv
// Job queue between front and back of the sliding trimmed-mean filter.
// Small register FIFO with first-word read. Depends on stmf_pkg.
module stmf_queue
  import stmf_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  job_t wr_data_i,
  output logic full_o,
  input  logic rd_i,
  output job_t rd_data_o,
  output logic empty_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  job_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_wr, do_rd;

  assign full_o    = (count_q == CntW'(DEPTH));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_i & ~full_o;
  assign do_rd     = rd_i & ~empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   count_q <= count_q + CntW'(1);
        2'b01:   count_q <= count_q - CntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// File: src/stmf_back.sv
// Back end of the sliding trimmed-mean filter: divide and repeat.
// Takes jobs from the queue into the result register. Depends on stmf_pkg.
module stmf_back
  import stmf_pkg::*;
#(
  parameter int unsigned WINDOW = WindowDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_empty_i,
  input  job_t      q_data_i,
  output logic      q_rd_o,
  output logic      empty,
  input  logic      pop,
  output out_item_t result_o
);

  localparam int unsigned SumW   = SampleBits + $clog2(WINDOW);
  localparam int unsigned Div    = WINDOW - 2;
  localparam int unsigned Shift  = SumW + $clog2(Div);
  localparam int unsigned RecipW = SumW + 1;
  localparam int unsigned ProdW  = SumW + RecipW;
  localparam int unsigned RepW   = $clog2(WINDOW + 1);
  localparam logic [63:0] Recip  = ((64'd1 << Shift) + 64'(Div) - 64'd1) / 64'(Div);

  logic            busy_q;
  sample_t         val_q;
  logic [RepW-1:0] rem_q;
  logic            runl_q, tend_q, unf_q;

  logic             last_copy;
  logic             advance;
  logic [ProdW-1:0] prod;
  sample_t          quot;

  assign last_copy = (rem_q == RepW'(1));
  assign advance   = ~busy_q | (pop & last_copy);
  assign q_rd_o    = advance & ~q_empty_i;

  assign prod = {RecipW'(0), q_data_i.value[SumW-1:0]} * {SumW'(0), Recip[RecipW-1:0]};
  assign quot = prod[Shift +: SampleBits];

  assign empty               = ~busy_q;
  assign result_o.filtered   = val_q;
  assign result_o.run_last   = runl_q & last_copy;
  assign result_o.track_end  = tend_q & last_copy;
  assign result_o.unfiltered = unf_q;

  always_ff @(posedge clk_i) begin
    if (q_rd_o) begin
      val_q  <= q_data_i.unfiltered ? q_data_i.value[SampleBits-1:0] : quot;
      runl_q <= q_data_i.run_last;
      tend_q <= q_data_i.track_end;
      unf_q  <= q_data_i.unfiltered;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rem_q  <= '0;
    end else if (q_rd_o) begin
      busy_q <= 1'b1;
      rem_q  <= q_data_i.reps[RepW-1:0];
    end else if (advance) begin
      busy_q <= 1'b0;
    end else if (pop) begin
      rem_q <= rem_q - RepW'(1);
    end
  end

endmodule

// File: src/sliding_trimmed_mean_filter.sv
// Top level of the sliding trimmed-mean filter: front, job queue and back.
// Depends on stmf_pkg, stmf_front, stmf_queue and stmf_back.
//
//   channel   handshake            payload      accepted when
//   input     push / full          in_item_i    push & !full
//   result    empty / pop          result_o     pop & !empty
//
// One sample a cycle while filling or running and the queue has room; one result
// a cycle while jobs are queued. A first or last window repeats its mean from the
// result register, and the queue absorbs the incoming samples meanwhile. A short
// track passes through unfiltered while full is high. Reset clears counts
// and queue; the window store needs no reset. Either side may stall on its own.
module sliding_trimmed_mean_filter
  import stmf_pkg::*;
#(
  parameter int unsigned WINDOW      = WindowDef,
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  input  in_item_t  in_item_i,
  output logic      full,
  output logic      empty,
  input  logic      pop,
  output out_item_t result_o
);

  logic q_full, q_empty, job_push, q_rd;
  job_t job, q_data;

  stmf_front #(
    .WINDOW(WINDOW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .in_item_i  (in_item_i),
    .full       (full),
    .q_full_i   (q_full),
    .job_push_o (job_push),
    .job_o      (job)
  );

  stmf_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (job_push),
    .wr_data_i (job),
    .full_o    (q_full),
    .rd_i      (q_rd),
    .rd_data_o (q_data),
    .empty_o   (q_empty)
  );

  stmf_back #(
    .WINDOW(WINDOW)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_data),
    .q_rd_o    (q_rd),
    .empty     (empty),
    .pop       (pop),
    .result_o  (result_o)
  );

endmodule

// File: tb/stmf_trim_checker.sv
// Checker for the sliding trimmed-mean filter: watches both channels and predicts
// every result from the accepted samples. Depends on stmf_pkg.
// Hands the mismatch count and the number of outstanding results to the testbench top.
module stmf_trim_checker
  import stmf_pkg::*;
#(
  parameter int unsigned WINDOW = WindowDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  in_item_t    in_item_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  out_item_t   result_i,
  output int unsigned mismatches_o,
  output int unsigned outstanding_o
);

  localparam int unsigned Lead  = (WINDOW - 1) / 2;
  localparam int unsigned Trail = WINDOW - 1 - Lead;

  sample_t     history [WINDOW-1];
  int unsigned fill_count;
  out_item_t   expected_results [$];
  int unsigned mismatches;
  int unsigned results_seen;

  task automatic report_mismatch(input string text);
    if (mismatches < 50) begin
      $display("%0t stmf_trim_checker: %s", $realtime, text);
    end
    mismatches++;
  endtask

  function automatic sample_t trimmed_mean(input sample_t newest);
    logic [31:0] total;
    sample_t     lowest;
    sample_t     highest;
    total   = 32'(newest);
    lowest  = newest;
    highest = newest;
    foreach (history[i]) begin
      total += 32'(history[i]);
      if (history[i] < lowest) lowest = history[i];
      if (history[i] > highest) highest = history[i];
    end
    return sample_t'((total - 32'(lowest) - 32'(highest)) / (WINDOW - 2));
  endfunction

  task automatic advance_track(input in_item_t item);
    out_item_t   res;
    sample_t     mean;
    int unsigned copies;
    if (fill_count < WINDOW - 1) begin
      if (!item.track_last) begin
        history[fill_count] = item.sample;
        fill_count++;
      end else begin
        for (int unsigned i = 0; i < fill_count; i++) begin
          res = '{filtered: history[i], run_last: 1'b0, track_end: 1'b0, unfiltered: 1'b1};
          expected_results = {expected_results, res};
        end
        res = '{filtered: item.sample, run_last: 1'b1, track_end: 1'b1, unfiltered: 1'b1};
        expected_results = {expected_results, res};
        fill_count = 0;
      end
    end else begin
      mean   = trimmed_mean(item.sample);
      copies = 1;
      if (fill_count == WINDOW - 1) copies += Lead;
      if (item.track_last) copies += Trail;
      for (int unsigned i = 0; i < WINDOW - 2; i++) begin
        history[i] = history[i+1];
      end
      history[WINDOW-2] = item.sample;
      fill_count = item.track_last ? 0 : WINDOW;
      for (int unsigned i = 0; i < copies; i++) begin
        res = '{filtered: mean, run_last: (i == copies - 1),
                track_end: (i == copies - 1) && item.track_last, unfiltered: 1'b0};
        expected_results = {expected_results, res};
      end
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with nothing expected: %h",
                                results_seen, got));
    end else begin
      want = expected_results.pop_front();
      if (got.filtered !== want.filtered) begin
        report_mismatch($sformatf("result %0d filtered %h, expected %h",
                                  results_seen, got.filtered, want.filtered));
      end
      if (got.run_last !== want.run_last) begin
        report_mismatch($sformatf("result %0d run_last %b, expected %b",
                                  results_seen, got.run_last, want.run_last));
      end
      if (got.track_end !== want.track_end) begin
        report_mismatch($sformatf("result %0d track_end %b, expected %b",
                                  results_seen, got.track_end, want.track_end));
      end
      if (got.unfiltered !== want.unfiltered) begin
        report_mismatch($sformatf("result %0d unfiltered %b, expected %b",
                                  results_seen, got.unfiltered, want.unfiltered));
      end
    end
    results_seen++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_count = 0;
      expected_results.delete();
      mismatches   = 0;
      results_seen = 0;
    end else begin
      if (push_i && !full_i) begin
        advance_track(in_item_i);
      end
      if (pop_i && !empty_i) begin
        check_result(result_i);
      end
    end
    mismatches_o  <= mismatches;
    outstanding_o <= expected_results.size();
  end

endmodule

// File: tb/sliding_trimmed_mean_filter_tb.sv
// Testbench top of the sliding trimmed-mean filter: clock, reset, sample tracks
// and result draining, with random idling on both sides and one long result stall.
// Depends on stmf_pkg, sliding_trimmed_mean_filter and stmf_trim_checker.
module sliding_trimmed_mean_filter_tb
  import stmf_pkg::*;
();

  localparam int unsigned CycleLimit   = 100000;
  localparam int unsigned RandomItems  = 80;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned HoldAtResult = 30;
  localparam int unsigned TailCycles   = 20;

  logic      clk_i   = 1'b0;
  logic      rst_ni  = 1'b0;
  logic      push    = 1'b0;
  in_item_t  in_item = '0;
  logic      full;
  logic      empty;
  logic      pop     = 1'b0;
  out_item_t result;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned samples_sent;
  int unsigned cycle_count;
  bit          results_held;
  bit          sender_steady;

  sliding_trimmed_mean_filter DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .in_item_i (in_item),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .result_o  (result)
  );

  stmf_trim_checker #(
    .WINDOW (WindowDef)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_i        (full),
    .in_item_i     (in_item),
    .empty_i       (empty),
    .pop_i         (pop),
    .result_i      (result),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("sliding_trimmed_mean_filter_tb: done, errors");
    $finish;
  end

  task automatic send_sample(input sample_t value, input logic last);
    int unsigned gap;
    gap = (sender_steady || results_held) ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push    <= 1'b1;
    in_item <= '{sample: value, track_last: last};
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    samples_sent++;
  endtask

  function automatic sample_t draw_sample(input sample_t base);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return sample_t'(base + $urandom_range(0, 3));
      default: return sample_t'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_track(input int unsigned len);
    sample_t base;
    base = sample_t'($urandom_range(0, 65535));
    sender_steady = ($urandom_range(0, 3) == 0);
    for (int unsigned n = 0; n < len; n++) begin
      send_sample(draw_sample(base), n == len - 1);
    end
  endtask

  initial begin : result_taker
    int unsigned gap;
    int unsigned taken;
    bit          steady;
    bit          held_once;
    taken     = 0;
    steady    = 1'b0;
    held_once = 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (taken == HoldAtResult && !held_once) begin
        held_once    = 1'b1;
        results_held = 1'b1;
        pop <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        results_held = 1'b0;
      end
      if (taken % 16 == 0) steady = ($urandom_range(0, 2) == 0);
      gap = steady ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      taken++;
    end
  end

  initial begin : sample_source
    sample_t     mixed [6];
    sample_t     edges [8];
    int unsigned random_start;
    int unsigned len;
    mixed = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF, 16'h1234};
    edges = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0005, 16'h0005, 16'h0005,
              16'h0000};
    samples_sent  = 0;
    results_held  = 1'b0;
    sender_steady = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_sample(16'hFFFF, 1'b1);
    for (int unsigned i = 0; i < 6; i++) begin
      send_sample(mixed[i], i == 5);
    end
    for (int unsigned i = 0; i < WindowDef; i++) begin
      send_sample(16'hFFFF, i == WindowDef - 1);
    end
    for (int unsigned i = 0; i < 8; i++) begin
      send_sample(edges[i], i == 7);
    end

    random_start = samples_sent;
    while (samples_sent - random_start < RandomItems) begin
      if ($urandom_range(0, 4) == 0) begin
        len = $urandom_range(1, WindowDef - 1);
      end else begin
        len = $urandom_range(WindowDef, 3 * WindowDef);
      end
      send_track(len);
    end
    push <= 1'b0;

    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("sliding_trimmed_mean_filter_tb: done, clean");
    end else begin
      $display("sliding_trimmed_mean_filter_tb: done, errors");
    end
    $finish;
  end

endmodule
